FILE: rtl/core/pgse_pkg.sv
// Shared constants, phase codes and the CRC-32 byte update for the PNG gray encoder.
package pgse_pkg;

  localparam int MaxDimension = 16384;
  localparam int DimW = 15;
  localparam int CountW = 14;
  localparam int RawW = 29;
  localparam logic [15:0] BlockLimit = 16'hffff;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [31:0] CrcPoly = 32'hedb88320;
  localparam logic [31:0] CrcInit = 32'hffffffff;

  localparam logic [0:0] RegWidth = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef logic [3:0] phase_t;

  localparam phase_t PhSig   = 4'd0;
  localparam phase_t PhIhdrL = 4'd1;
  localparam phase_t PhIhdr  = 4'd2;
  localparam phase_t PhHcrc  = 4'd3;
  localparam phase_t PhIdatL = 4'd4;
  localparam phase_t PhIdat  = 4'd5;
  localparam phase_t PhFhdr  = 4'd6;
  localparam phase_t PhFilt  = 4'd7;
  localparam phase_t PhPhdr  = 4'd8;
  localparam phase_t PhPix   = 4'd9;
  localparam phase_t PhAdler = 4'd10;
  localparam phase_t PhDcrc  = 4'd11;
  localparam phase_t PhIendL = 4'd12;
  localparam phase_t PhIend  = 4'd13;
  localparam phase_t PhEcrc  = 4'd14;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [RawW-1:0] raw_total;
    logic [31:0]     idat_len;
  } geom_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/pgse_geom.sv
// Frame geometry: clamped size, raw byte total and IDAT length.
module pgse_geom (
  input  logic                       clk,
  input  logic [pgse_pkg::DimW-1:0]  cfg_width,
  input  logic [pgse_pkg::DimW-1:0]  cfg_height,
  output pgse_pkg::geom_t            geom
);
  import pgse_pkg::*;

  logic [DimW-1:0] w_eff;
  logic [DimW-1:0] h_eff;
  logic [RawW-1:0] raw;
  logic [31:0]     len;
  logic [12:0]     q;
  logic [16:0]     s;
  logic [16:0]     rem;
  logic            corr;
  logic [13:0]     nblk;

  always_comb begin
    if (cfg_width < DimW'(2)) w_eff = DimW'(2);
    else if (cfg_width > DimW'(MaxDimension)) w_eff = DimW'(MaxDimension);
    else w_eff = cfg_width;
    if (cfg_height < DimW'(1)) h_eff = DimW'(1);
    else if (cfg_height > DimW'(MaxDimension)) h_eff = DimW'(MaxDimension);
    else h_eff = cfg_height;
  end

  always_ff @(posedge clk) begin
    raw <= RawW'(({15'd0, w_eff} + 30'd1) * {15'd0, h_eff});
    len <= 32'd6 + {16'd0, nblk, 2'b00} + {18'd0, nblk} + {3'd0, raw};
  end

  // ceil(raw / 65535) using 65535 = 2^16 - 1
  always_comb begin
    q    = raw[RawW-1:16];
    s    = {4'd0, q} + {1'b0, raw[15:0]};
    corr = s >= {1'b0, BlockLimit};
    rem  = corr ? s - {1'b0, BlockLimit} : s;
    nblk = {1'b0, q} + {13'd0, corr} + {13'd0, rem != 17'd0};
  end

  assign geom.width     = w_eff;
  assign geom.height    = h_eff;
  assign geom.raw_total = raw;
  assign geom.idat_len  = len;

endmodule

FILE: rtl/core/png_gray_stored_stream_encoder_unit.sv
// Top level: streaming PNG encoder for 8-bit gray pixels using stored deflate blocks.
//
//   channel | dir | signals                         | content
//   s_axis  | in  | s_tvalid s_tready s_tdata[7:0]  | pixel
//   m_axis  | out | m_tvalid m_tready m_tdata[7:0]  | out_byte, tlast last_of_run,
//           |     | m_tlast m_tuser                 | tuser end_of_file
//   cfg     | in  | cfg_we cfg_index cfg_data[14:0] | 0 image_width, 1 image_height
//
// One file byte leaves per cycle, unless the output stalls, from a one-byte output register;
// a pixel releases 1 byte inside a row, 2 at a row start, 5 more at a block start, 50 for
// the first pixel and 20 more for the last. The byte sequencer sets these byte counts.
// A pixel is taken in the cycle its predecessor releases its final byte.
// Reset is synchronous and clears all control state. A stalled output holds the sequencer.
module png_gray_stored_stream_encoder_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // pixel[7:0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // out_byte[7:0]
  output logic                      m_tlast,
  output logic                      m_tuser,   // end_of_file
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [pgse_pkg::DimW-1:0] cfg_data
);
  import pgse_pkg::*;

  logic [DimW-1:0]   cfg_width;
  logic [DimW-1:0]   cfg_height;
  geom_t             geom;

  logic              hold_valid;
  logic [7:0]        hold_pixel;
  phase_t            phase, phase_next, entry;
  logic [4:0]        cnt, cnt_next;
  logic [31:0]       crc, crc_next;
  logic [15:0]       adler_low, adler_low_next;
  logic [15:0]       adler_high, adler_high_next;
  logic [CountW-1:0] col, col_next;
  logic [CountW-1:0] row, row_next;
  logic [15:0]       fill, fill_next;
  logic [RawW-1:0]   rem, rem_next;
  logic              in_frame, in_frame_next;

  logic              emit, fin, eof, accept;
  logic [7:0]        byte_val;
  logic              crc_on, crc_init;
  logic [4:0]        last_cnt;
  logic              last_ph;
  logic [16:0]       al_sum, ah_sum;
  logic [15:0]       al_new;
  logic [15:0]       blen;
  logic              last_col, done;

  pgse_geom u_geom (
    .clk        (clk),
    .cfg_width  (cfg_width),
    .cfg_height (cfg_height),
    .geom       (geom)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= DimW'(2);
      cfg_height <= DimW'(1);
    end else if (cfg_we && !in_frame && !hold_valid) begin
      unique case (cfg_index)
        RegWidth:  cfg_width  <= cfg_data;
        RegHeight: cfg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign emit     = hold_valid && (!m_tvalid || m_tready);
  assign last_col = {1'b0, col} == geom.width - DimW'(1);
  assign done     = last_col && ({1'b0, row} == geom.height - DimW'(1));
  assign blen     = (rem >= {13'd0, BlockLimit}) ? BlockLimit : rem[15:0];
  assign last_ph  = cnt == last_cnt;

  always_comb begin
    byte_val = 8'd0;
    crc_on   = 1'b1;
    crc_init = 1'b0;
    last_cnt = 5'd3;
    unique case (phase)
      PhSig: begin
        crc_on   = 1'b0;
        last_cnt = 5'd7;
        unique case (cnt[2:0])
          3'd0: byte_val = 8'h89;
          3'd1: byte_val = 8'h50;
          3'd2: byte_val = 8'h4e;
          3'd3: byte_val = 8'h47;
          3'd4: byte_val = 8'h0d;
          3'd5: byte_val = 8'h0a;
          3'd6: byte_val = 8'h1a;
          default: byte_val = 8'h0a;
        endcase
      end
      PhIhdrL: begin
        crc_on   = 1'b0;
        byte_val = (cnt == 5'd3) ? 8'd13 : 8'd0;
      end
      PhIhdr: begin
        last_cnt = 5'd16;
        crc_init = cnt == 5'd0;
        unique case (cnt)
          5'd0:  byte_val = 8'h49;
          5'd1:  byte_val = 8'h48;
          5'd2:  byte_val = 8'h44;
          5'd3:  byte_val = 8'h52;
          5'd6:  byte_val = {1'b0, geom.width[14:8]};
          5'd7:  byte_val = geom.width[7:0];
          5'd10: byte_val = {1'b0, geom.height[14:8]};
          5'd11: byte_val = geom.height[7:0];
          5'd12: byte_val = 8'd8;
          default: byte_val = 8'd0;
        endcase
      end
      PhHcrc, PhDcrc, PhEcrc: begin
        crc_on = 1'b0;
        unique case (cnt[1:0])
          2'd0: byte_val = ~crc[31:24];
          2'd1: byte_val = ~crc[23:16];
          2'd2: byte_val = ~crc[15:8];
          default: byte_val = ~crc[7:0];
        endcase
      end
      PhIdatL: begin
        crc_on = 1'b0;
        unique case (cnt[1:0])
          2'd0: byte_val = geom.idat_len[31:24];
          2'd1: byte_val = geom.idat_len[23:16];
          2'd2: byte_val = geom.idat_len[15:8];
          default: byte_val = geom.idat_len[7:0];
        endcase
      end
      PhIdat: begin
        last_cnt = 5'd5;
        crc_init = cnt == 5'd0;
        unique case (cnt[2:0])
          3'd0: byte_val = 8'h49;
          3'd1: byte_val = 8'h44;
          3'd2: byte_val = 8'h41;
          3'd3: byte_val = 8'h54;
          3'd4: byte_val = 8'h78;
          default: byte_val = 8'h01;
        endcase
      end
      PhFhdr, PhPhdr: begin
        last_cnt = 5'd4;
        unique case (cnt[2:0])
          3'd0: byte_val = {7'd0, rem <= {13'd0, BlockLimit}};
          3'd1: byte_val = blen[7:0];
          3'd2: byte_val = blen[15:8];
          3'd3: byte_val = ~blen[7:0];
          default: byte_val = ~blen[15:8];
        endcase
      end
      PhFilt: begin
        last_cnt = 5'd0;
        byte_val = 8'd0;
      end
      PhPix: begin
        last_cnt = 5'd0;
        byte_val = hold_pixel;
      end
      PhAdler: begin
        unique case (cnt[1:0])
          2'd0: byte_val = adler_high[15:8];
          2'd1: byte_val = adler_high[7:0];
          2'd2: byte_val = adler_low[15:8];
          default: byte_val = adler_low[7:0];
        endcase
      end
      PhIendL: begin
        crc_on = 1'b0;
      end
      PhIend: begin
        crc_init = cnt == 5'd0;
        unique case (cnt[1:0])
          2'd0: byte_val = 8'h49;
          2'd1: byte_val = 8'h45;
          2'd2: byte_val = 8'h4e;
          default: byte_val = 8'h44;
        endcase
      end
      default: begin
        crc_on = 1'b0;
      end
    endcase
  end

  always_comb begin
    al_sum = {1'b0, adler_low} + {9'd0, byte_val};
    al_new = (al_sum >= AdlerMod) ? 16'(al_sum - AdlerMod) : al_sum[15:0];
    ah_sum = {1'b0, adler_high} + {1'b0, al_new};
  end

  always_comb begin
    phase_next      = phase;
    cnt_next        = cnt;
    crc_next        = crc;
    adler_low_next  = adler_low;
    adler_high_next = adler_high;
    col_next        = col;
    row_next        = row;
    fill_next       = fill;
    rem_next        = rem;
    in_frame_next   = in_frame;
    fin             = 1'b0;
    eof             = 1'b0;
    if (emit) begin
      cnt_next = last_ph ? 5'd0 : cnt + 5'd1;
      if (crc_on) crc_next = crc_byte(crc_init ? CrcInit : crc, byte_val);
      if (phase == PhSig) in_frame_next = 1'b1;
      if (phase == PhIdatL) rem_next = geom.raw_total;
      if (phase == PhFilt || phase == PhPix) begin
        adler_low_next  = al_new;
        adler_high_next = (ah_sum >= AdlerMod) ? 16'(ah_sum - AdlerMod) : ah_sum[15:0];
        if (rem != '0) rem_next = rem - RawW'(1);
        fill_next = (fill + 16'd1 == BlockLimit) ? 16'd0 : fill + 16'd1;
      end
      if (phase == PhPix) begin
        if (last_col) begin
          col_next = '0;
          row_next = row + CountW'(1);
        end else begin
          col_next = col + CountW'(1);
        end
        if (done) begin
          col_next  = '0;
          row_next  = '0;
          fill_next = '0;
          rem_next  = '0;
        end else begin
          fin = 1'b1;
        end
      end
      if (phase == PhEcrc && last_ph) begin
        fin             = 1'b1;
        eof             = 1'b1;
        in_frame_next   = 1'b0;
        adler_low_next  = 16'd1;
        adler_high_next = 16'd0;
        crc_next        = CrcInit;
      end
      if (last_ph) begin
        unique case (phase)
          PhSig:   phase_next = PhIhdrL;
          PhIhdrL: phase_next = PhIhdr;
          PhIhdr:  phase_next = PhHcrc;
          PhHcrc:  phase_next = PhIdatL;
          PhIdatL: phase_next = PhIdat;
          PhIdat:  phase_next = PhFhdr;
          PhFhdr:  phase_next = PhFilt;
          PhFilt:  phase_next = (fill_next == 16'd0) ? PhPhdr : PhPix;
          PhPhdr:  phase_next = PhPix;
          PhPix:   phase_next = PhAdler;
          PhAdler: phase_next = PhDcrc;
          PhDcrc:  phase_next = PhIendL;
          PhIendL: phase_next = PhIend;
          PhIend:  phase_next = PhEcrc;
          default: phase_next = PhSig;
        endcase
      end
    end
  end

  always_comb begin
    if (!in_frame_next) entry = PhSig;
    else if (col_next == '0) entry = (fill_next == 16'd0) ? PhFhdr : PhFilt;
    else entry = (fill_next == 16'd0) ? PhPhdr : PhPix;
  end

  assign s_tready = !hold_valid || (emit && fin);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= PhSig;
      cnt        <= '0;
      crc        <= CrcInit;
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
      col        <= '0;
      row        <= '0;
      fill       <= '0;
      rem        <= '0;
      in_frame   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      crc        <= crc_next;
      adler_low  <= adler_low_next;
      adler_high <= adler_high_next;
      col        <= col_next;
      row        <= row_next;
      fill       <= fill_next;
      rem        <= rem_next;
      in_frame   <= in_frame_next;
      if (accept) begin
        hold_valid <= 1'b1;
        phase      <= entry;
        cnt        <= '0;
      end else begin
        if (emit && fin) hold_valid <= 1'b0;
        phase <= phase_next;
        cnt   <= cnt_next;
      end
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hold_pixel <= s_tdata;
    if (emit) begin
      m_tdata <= byte_val;
      m_tlast <= fin;
      m_tuser <= eof;
    end
  end

endmodule

FILE: rtl/core/pgse_checker.sv
// Port-level checker for the PNG gray encoder, bound to the top level.
module pgse_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transfer changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("end of file without last of run");

endmodule

bind png_gray_stored_stream_encoder_unit pgse_checker u_pgse_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

FILE: sim/png_gray_stored_stream_encoder_unit_test.sv
// Testbench for the streaming PNG gray encoder: directed table, random frames, own predictor.
module png_gray_stored_stream_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pgse_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
  } png_byte_t;

  typedef enum logic {OpCfg, OpPix} step_op_t;

  typedef struct packed {
    step_op_t    op;
    logic [0:0]  idx;
    logic [14:0] val;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tlast;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [DimW-1:0] cfg_data = '0;

  png_gray_stored_stream_encoder_unit dut (.*);

  always #1 clk = ~clk;

  png_byte_t file_q[$];
  int unsigned width_reg, height_reg;
  logic [31:0] crc_acc;
  int unsigned adler_lo, adler_hi, col_cnt, row_cnt, blk_fill, raw_left;
  bit frame_open;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixels_sent = 0;
  int bytes_seen = 0;
  int frames_done = 0;
  int recv_hold = 0;
  bit hold_done = 1'b0;

  function automatic int unsigned eff_w();
    return width_reg < 2 ? 2 : (width_reg > MaxDimension ? MaxDimension : width_reg);
  endfunction

  function automatic int unsigned eff_h();
    return height_reg < 1 ? 1 : (height_reg > MaxDimension ? MaxDimension : height_reg);
  endfunction

  task automatic emit(input logic [7:0] b, input bit crc_on);
    png_byte_t item;
    item = '{data: b, last: 1'b0, eof: 1'b0};
    if (crc_on) begin
      crc_acc = crc_acc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) crc_acc = (crc_acc >> 1) ^ (32'hedb88320 & {32{crc_acc[0]}});
    end
    file_q.insert(file_q.size(), item);
  endtask

  task automatic emit32(input logic [31:0] v, input bit crc_on);
    for (int i = 3; i >= 0; i--) emit(v[8*i +: 8], crc_on);
  endtask

  task automatic chunk_head(input logic [31:0] len, input logic [31:0] tag);
    emit32(len, 1'b0);
    crc_acc = 32'hffffffff;
    emit32(tag, 1'b1);
  endtask

  task automatic emit_raw(input logic [7:0] b);
    int unsigned len;
    if (blk_fill == 0) begin
      len = raw_left < 65535 ? raw_left : 65535;
      emit(raw_left <= 65535 ? 8'd1 : 8'd0, 1'b1);
      emit(len[7:0], 1'b1);
      emit(len[15:8], 1'b1);
      emit(~len[7:0], 1'b1);
      emit(~len[15:8], 1'b1);
    end
    emit(b, 1'b1);
    adler_lo = (adler_lo + b) % 65521;
    adler_hi = (adler_hi + adler_lo) % 65521;
    if (raw_left > 0) raw_left--;
    blk_fill++;
    if (blk_fill >= 65535) blk_fill = 0;
  endtask

  task automatic predict_pixel(input logic [7:0] p);
    longint unsigned raw, nblk;
    logic [31:0] idat_len;
    bit done;
    done = 1'b0;
    if (!frame_open) begin
      raw = longint'(eff_w() + 1) * eff_h();
      nblk = (raw + 65534) / 65535;
      idat_len = 32'(2 + 5 * nblk + raw + 4);
      emit32(32'h89504e47, 1'b0);
      emit32(32'h0d0a1a0a, 1'b0);
      chunk_head(32'd13, 32'h49484452);
      emit32(eff_w(), 1'b1);
      emit32(eff_h(), 1'b1);
      emit(8'd8, 1'b1);
      for (int i = 0; i < 4; i++) emit(8'd0, 1'b1);
      emit32(~crc_acc, 1'b0);
      chunk_head(idat_len, 32'h49444154);
      emit(8'h78, 1'b1);
      emit(8'h01, 1'b1);
      adler_lo = 1; adler_hi = 0; col_cnt = 0; row_cnt = 0; blk_fill = 0;
      raw_left = 32'(raw);
      frame_open = 1'b1;
    end
    if (col_cnt == 0) emit_raw(8'd0);
    emit_raw(p);
    col_cnt++;
    if (col_cnt >= eff_w()) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= eff_h()) done = 1'b1;
    end
    if (done) begin
      emit32({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
      emit32(~crc_acc, 1'b0);
      chunk_head(32'd0, 32'h49454e44);
      emit32(~crc_acc, 1'b0);
      crc_acc = 32'hffffffff;
      adler_lo = 1; adler_hi = 0; col_cnt = 0; row_cnt = 0; blk_fill = 0; raw_left = 0;
      frame_open = 1'b0;
      frames_done++;
    end
    file_q[file_q.size()-1].last = 1'b1;
    if (done) file_q[file_q.size()-1].eof = 1'b1;
  endtask

  // receiver: checks every transfer, random stall, one long hold-off early on
  always @(posedge clk) begin
    png_byte_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        bytes_seen++;
        if (file_q.size() == 0) begin
          $display("%0t: unexpected byte %h last %b eof %b", $time, m_tdata, m_tlast, m_tuser);
          errors++;
        end else begin
          want = file_q.pop_front();
          if (want != {m_tdata, m_tlast, m_tuser}) begin
            $display("%0t: expected %h/%b/%b got %h/%b/%b", $time, want.data, want.last,
                     want.eof, m_tdata, m_tlast, m_tuser);
            errors++;
          end
        end
      end
      if (!hold_done && bytes_seen >= 100) begin
        hold_done = 1'b1;
        recv_hold = 400;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    predict_pixel(p);
    pixels_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (file_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [14:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (!frame_open) begin
      if (idx == RegWidth) width_reg = 32'(val);
      else height_reg = 32'(val);
    end
  endtask

  task automatic send_frame(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(8'($urandom));
  endtask

  step_t directed[] = '{
    '{OpPix, RegWidth, 15'h00},  // reset size 2x1
    '{OpPix, RegWidth, 15'hff},
    '{OpCfg, RegWidth, 15'd0},   // clamps to 2
    '{OpCfg, RegHeight, 15'd0},  // clamps to 1
    '{OpPix, RegWidth, 15'hff},
    '{OpPix, RegWidth, 15'h00},
    '{OpCfg, RegWidth, 15'd1},
    '{OpCfg, RegHeight, 15'd2},
    '{OpPix, RegWidth, 15'h55},
    '{OpCfg, RegWidth, 15'd9},   // mid-frame, ignored
    '{OpCfg, RegHeight, 15'd5},  // mid-frame, ignored
    '{OpPix, RegWidth, 15'haa},
    '{OpPix, RegWidth, 15'h01},
    '{OpPix, RegWidth, 15'h80},
    '{OpCfg, RegWidth, 15'd3},
    '{OpCfg, RegHeight, 15'd3},
    '{OpPix, RegWidth, 15'h7f},
    '{OpPix, RegWidth, 15'hfe},
    '{OpPix, RegWidth, 15'h00},
    '{OpPix, RegWidth, 15'hff},
    '{OpPix, RegWidth, 15'h10},
    '{OpPix, RegWidth, 15'h20},
    '{OpPix, RegWidth, 15'h40},
    '{OpPix, RegWidth, 15'h08},
    '{OpPix, RegWidth, 15'h04}
  };

  initial begin
    int phase_pixels;
    width_reg = 2; height_reg = 1; crc_acc = 32'hffffffff;
    adler_lo = 1; adler_hi = 0; col_cnt = 0; row_cnt = 0; blk_fill = 0; raw_left = 0;
    frame_open = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].op == OpCfg) write_reg(directed[i].idx, directed[i].val);
      else send_pixel(directed[i].val[7:0]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 26 : (ph == 1 ? 84 : 0);
      recv_idle_pct = ph == 0 ? 84 : (ph == 1 ? 26 : 0);
      phase_pixels = 0;
      while (phase_pixels < 110) begin
        write_reg(RegWidth, $urandom_range(9) == 0 ? 15'($urandom_range(1)) :
                            15'($urandom_range(24, 2)));
        write_reg(RegHeight, 15'($urandom_range(5)));
        phase_pixels += eff_w() * eff_h();
        send_frame(eff_w() * eff_h());
      end
    end

    // top register values clamp to 16384 by 16384; a partial frame covers the header,
    // the large IDAT length and a non-final stored block header
    write_reg(RegWidth, 15'h7fff);
    write_reg(RegHeight, 15'h7ffe);
    send_frame(16);
    drain();
    repeat (50) @(posedge clk);

    $display("%0d pixels in %0d finished frames, %0d file bytes checked", pixels_sent,
             frames_done, bytes_seen);
    $display("sizes from clamped minimum up to a clamped 16384 by 16384 header, mid-frame writes,"
             , " idle mixes");
    if (errors == 0 && file_q.size() == 0) begin
      $display("png_gray_stored_stream_encoder_unit_test: clean");
    end else begin
      $display("png_gray_stored_stream_encoder_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("png_gray_stored_stream_encoder_unit_test: errors");
    $finish;
  end

endmodule

FILE: png_gray_stored_stream_encoder_unit.f
rtl/core/pgse_pkg.sv
rtl/core/pgse_geom.sv
rtl/core/png_gray_stored_stream_encoder_unit.sv
rtl/core/pgse_checker.sv
sim/png_gray_stored_stream_encoder_unit_test.sv
